FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/bzfw_pkg.sv
`default_nettype none

package bzfw_pkg;

    localparam int SRC_DEPTH = 65536;
    localparam int SRC_AW    = $clog2(SRC_DEPTH);
    localparam int DST_MAX   = 1024;

    localparam int SW_W   = 8;
    localparam int DIM_W  = 10;
    localparam int DIV_W  = DIM_W + 1;
    localparam int CNT_W  = 10;
    localparam int PEN_W  = 12;
    localparam int LB_W   = 14;
    localparam int ADDR_W = 27;
    localparam int PIX_W  = 32;
    localparam int BC_W   = 3;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;
    localparam int PROD_W = CNT_W + SW_W;
    localparam int IDX_W  = PROD_W + SW_W + 1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    localparam logic [1:0] MODE_8BPP  = 2'd0;
    localparam logic [1:0] MODE_16BPP = 2'd1;
    localparam logic [1:0] MODE_32BPP = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [CFG_AW-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_PEN_X      = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_PEN_Y      = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_PIXEL_MODE = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_LINE_BYTES = 3'd7;

    localparam logic [23:0] COLOR_WHITE = 24'hffffff;
    localparam logic [23:0] COLOR_BLACK = 24'h000000;
    localparam logic [7:0]  BYTE_MASK   = 8'hff;
    localparam int          RGB_R_SHIFT = 11;
    localparam int          RGB_G_SHIFT = 5;

    // zero counts as one, clamp to DST_MAX
    function automatic logic [DIV_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIV_W-1:0] e;
        e = {1'b0, d};
        if (d == '0)
            e = DIV_W'(1);
        else if (int'(d) > DST_MAX)
            e = DIV_W'(DST_MAX);
        return e;
    endfunction

    function automatic logic [BC_W-1:0] bytes_per_pixel(input logic [1:0] mode);
        logic [BC_W-1:0] n;
        unique case (mode)
            MODE_8BPP:  n = BC_W'(1);
            MODE_16BPP: n = BC_W'(2);
            MODE_32BPP: n = BC_W'(4);
            default:    n = '0;
        endcase
        return n;
    endfunction

    function automatic logic [PIX_W-1:0] encode_pixel(input logic dark, input logic [1:0] mode);
        logic [23:0]      color;
        logic [7:0]       r;
        logic [7:0]       g;
        logic [7:0]       b;
        logic [PIX_W-1:0] v;
        color = dark ? COLOR_BLACK : COLOR_WHITE;
        r = color[23:16];
        g = color[15:8];
        b = color[7:0];
        unique case (mode)
            MODE_8BPP:  v = PIX_W'(color[7:0] & BYTE_MASK);
            MODE_16BPP: v = (PIX_W'(r >> 3) << RGB_R_SHIFT) | (PIX_W'(g >> 2) << RGB_G_SHIFT)
                            | PIX_W'(b >> 3);
            MODE_32BPP: v = PIX_W'(color);
            default:    v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: design/bitmap_zoom_framebuffer_writer_unit.sv
// Load item: taken only in idle, writes the module store, no result.
// Emit item: steps S_MUL, S_DIV, S_IDX, S_RD, S_OUT; result registered on leaving S_OUT,
// next item taken back in S_IDLE; the two bit-serial dividers (18 steps) run in S_DIV.
// A result waiting in the output register does not block new items, but a stalled one holds S_OUT.
// Reset clears counters, output valid and loads default registers; store is not cleared.
`default_nettype none

`include "assert_macros.svh"

module bitmap_zoom_framebuffer_writer_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           command,
    input  wire logic [15:0]                    src_index,
    input  wire logic                           module_value,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [bzfw_pkg::ADDR_W-1:0]         fb_address,
    output logic [bzfw_pkg::PIX_W-1:0]          pixel_value,
    output logic [bzfw_pkg::BC_W-1:0]           byte_count,
    output logic                                last,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [bzfw_pkg::CFG_AW-1:0]    cfg_addr,
    input  wire logic [bzfw_pkg::CFG_DW-1:0]    cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_IDX  = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam int PW = bzfw_pkg::PEN_W + 1;
    localparam int CW = bzfw_pkg::CNT_W;
    localparam int AW = bzfw_pkg::ADDR_W;

    logic [2:0] state_reg, state_next;

    logic [bzfw_pkg::SW_W-1:0]  src_width_reg, src_height_reg;
    logic [bzfw_pkg::DIM_W-1:0] dst_width_reg, dst_height_reg;
    logic [bzfw_pkg::PEN_W-1:0] pen_x_reg, pen_y_reg;
    logic [1:0]                 pixel_mode_reg;
    logic [bzfw_pkg::LB_W-1:0]  line_bytes_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [CW-1:0] row_reg, row_next;

    logic [bzfw_pkg::PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic [AW-1:0]               addr_reg;
    logic [bzfw_pkg::IDX_W-1:0]  idx_reg;
    logic                        rd_reg;

    logic                          out_valid_reg, out_valid_next;
    logic [AW-1:0]                 fb_address_reg;
    logic [bzfw_pkg::PIX_W-1:0]    pixel_value_reg;
    logic [bzfw_pkg::BC_W-1:0]     byte_count_reg;
    logic                          last_reg;

    logic mem [bzfw_pkg::SRC_DEPTH];

    logic                        in_take, load_take, emit_take, out_load;
    logic                        div_start, div_x_busy, div_y_busy;
    logic [bzfw_pkg::PROD_W-1:0] sx_q, sy_q;
    logic [bzfw_pkg::DIV_W-1:0]  dw_eff, dh_eff;
    logic [bzfw_pkg::BC_W-1:0]   bpp;
    logic [PW-1:0]               line_pos, col_pos;
    logic [AW-1:0]               addr_calc;
    logic                        dark;
    logic                        col_end, row_end;

    assign in_stall  = state_reg != S_IDLE;
    assign in_take   = in_valid && !in_stall;
    assign load_take = in_take && (command == bzfw_pkg::CMD_LOAD);
    assign emit_take = in_take && (command == bzfw_pkg::CMD_EMIT);
    assign cfg_ready = 1'b1;
    assign div_start = state_reg == S_MUL;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    assign dw_eff = bzfw_pkg::eff_dim(dst_width_reg);
    assign dh_eff = bzfw_pkg::eff_dim(dst_height_reg);
    assign bpp    = bzfw_pkg::bytes_per_pixel(pixel_mode_reg);

    assign line_pos  = PW'(pen_y_reg) + PW'(row_reg);
    assign col_pos   = PW'(pen_x_reg) + PW'(col_reg);
    assign addr_calc = (bpp == '0) ? '0
                     : AW'(AW'(line_pos) * AW'(line_bytes_reg) + AW'(col_pos) * AW'(bpp));

    assign dark    = rd_reg && (idx_reg < bzfw_pkg::IDX_W'(bzfw_pkg::SRC_DEPTH));
    assign col_end = ({1'b0, col_reg} + (CW + 1)'(1)) >= dw_eff;
    assign row_end = ({1'b0, row_reg} + (CW + 1)'(1)) >= dh_eff;

    bzfw_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_x_reg),
        .divisor  (dw_eff),
        .busy     (div_x_busy),
        .quotient (sx_q)
    );

    bzfw_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_y_reg),
        .divisor  (dh_eff),
        .busy     (div_y_busy),
        .quotient (sy_q)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (emit_take) state_next = S_MUL;
            S_MUL:   state_next = S_DIV;
            S_DIV:   if (!div_x_busy && !div_y_busy) state_next = S_IDX;
            S_IDX:   state_next = S_RD;
            S_RD:    state_next = S_OUT;
            S_OUT:   if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (out_load)
        begin
            if (col_end)
            begin
                col_next = '0;
                row_next = row_end ? '0 : row_reg + CW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            col_reg        <= '0;
            row_reg        <= '0;
            out_valid_reg  <= 1'b0;
            src_width_reg  <= 8'd21;
            src_height_reg <= 8'd21;
            dst_width_reg  <= 10'd42;
            dst_height_reg <= 10'd42;
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            pixel_mode_reg <= bzfw_pkg::MODE_16BPP;
            line_bytes_reg <= 14'd1280;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_addr)
                    bzfw_pkg::CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[bzfw_pkg::SW_W-1:0];
                    bzfw_pkg::CFG_SRC_HEIGHT: src_height_reg <= cfg_data[bzfw_pkg::SW_W-1:0];
                    bzfw_pkg::CFG_DST_WIDTH:  dst_width_reg  <= cfg_data[bzfw_pkg::DIM_W-1:0];
                    bzfw_pkg::CFG_DST_HEIGHT: dst_height_reg <= cfg_data[bzfw_pkg::DIM_W-1:0];
                    bzfw_pkg::CFG_PEN_X:      pen_x_reg      <= cfg_data[bzfw_pkg::PEN_W-1:0];
                    bzfw_pkg::CFG_PEN_Y:      pen_y_reg      <= cfg_data[bzfw_pkg::PEN_W-1:0];
                    bzfw_pkg::CFG_PIXEL_MODE: pixel_mode_reg <= cfg_data[1:0];
                    bzfw_pkg::CFG_LINE_BYTES: line_bytes_reg <= cfg_data[bzfw_pkg::LB_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (emit_take)
        begin
            prod_x_reg <= bzfw_pkg::PROD_W'(bzfw_pkg::PROD_W'(col_reg)
                          * bzfw_pkg::PROD_W'(src_width_reg));
            prod_y_reg <= bzfw_pkg::PROD_W'(bzfw_pkg::PROD_W'(row_reg)
                          * bzfw_pkg::PROD_W'(src_height_reg));
        end
        if (state_reg == S_MUL)
            addr_reg <= addr_calc;
        if (state_reg == S_IDX)
            idx_reg <= bzfw_pkg::IDX_W'(bzfw_pkg::IDX_W'(sy_q) * bzfw_pkg::IDX_W'(src_width_reg)
                       + bzfw_pkg::IDX_W'(sx_q));
        if (out_load)
        begin
            fb_address_reg  <= addr_reg;
            pixel_value_reg <= bzfw_pkg::encode_pixel(dark, pixel_mode_reg);
            byte_count_reg  <= bpp;
            last_reg        <= col_end && row_end;
        end
    end

    // module store
    always_ff @(posedge clk)
    begin
        if (load_take && (int'(src_index) < bzfw_pkg::SRC_DEPTH))
            mem[src_index[bzfw_pkg::SRC_AW-1:0]] <= module_value;
        if (state_reg == S_RD)
            rd_reg <= mem[idx_reg[bzfw_pkg::SRC_AW-1:0]];
    end

    assign out_valid   = out_valid_reg;
    assign fb_address  = fb_address_reg;
    assign pixel_value = pixel_value_reg;
    assign byte_count  = byte_count_reg;
    assign last        = last_reg;

    `ASSERT_NEXT(a_emit_blocks_input, clk, rst_n, emit_take, in_stall)
    `ASSERT_IMPL(a_last_wraps, clk, rst_n, out_valid_reg && last_reg,
                 col_reg == '0 && row_reg == '0)
    `ASSERT_IMPL(a_unsupported_zero, clk, rst_n, out_valid_reg && byte_count_reg == '0,
                 fb_address_reg == '0 && pixel_value_reg == '0)
    `ASSERT_IMPL(a_div_only_in_div, clk, rst_n, div_x_busy || div_y_busy, state_reg == S_DIV)

endmodule

`default_nettype wire

FILE: design/bzfw_div.sv
`default_nettype none

module bzfw_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [bzfw_pkg::PROD_W-1:0]  dividend,
    input  wire logic [bzfw_pkg::DIV_W-1:0]   divisor,
    output logic                              busy,
    output logic [bzfw_pkg::PROD_W-1:0]       quotient
);

    localparam int STEPS = bzfw_pkg::PROD_W;
    localparam int CW    = $clog2(STEPS + 1);

    logic [CW-1:0]                   count_reg, count_next;
    logic [bzfw_pkg::PROD_W-1:0]     quo_reg, quo_next;
    logic [bzfw_pkg::DIV_W-1:0]      rem_reg, rem_next;
    logic [bzfw_pkg::DIV_W-1:0]      div_reg, div_next;
    logic [bzfw_pkg::DIV_W:0]        trial;
    logic [bzfw_pkg::DIV_W:0]        diff;
    logic                            ge;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        trial      = {rem_reg, quo_reg[bzfw_pkg::PROD_W-1]};
        diff       = trial - {1'b0, div_reg};
        ge         = trial >= {1'b0, div_reg};
        count_next = count_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (start)
        begin
            count_next = CW'(STEPS);
            quo_next   = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (count_reg != '0)
        begin
            count_next = count_reg - CW'(1);
            quo_next   = {quo_reg[bzfw_pkg::PROD_W-2:0], ge};
            rem_next   = ge ? diff[bzfw_pkg::DIV_W-1:0] : trial[bzfw_pkg::DIV_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy     = count_reg != '0;
    assign quotient = quo_reg;

endmodule

`default_nettype wire
